// ===== design/ensc_pkg.sv =====
package ensc_pkg;

  // Pipeline depth from input register to the last datapath stage
  localparam int PIPE_DEPTH = 86;

  // Operand widths of the division
  localparam int NUM_W = 64;
  localparam int DIV_W = 31;

  // Fixed-point constants of the compensation
  localparam int P_TF_OFF  = 128000;
  localparam int P_BASE    = 1048576;
  localparam int P_SCALE   = 3125;
  localparam int H_TF_OFF  = 76800;
  localparam int H_CLAMP   = 419430400;
  localparam int H_ROUND1  = 16384;
  localparam int H_BIAS    = 2097152;
  localparam int H_ROUND2  = 8192;
  localparam int H_BIAS2   = 32768;
  localparam int HUM_W     = 17;
  localparam logic [HUM_W-1:0] HUM_MAX = HUM_W'(H_CLAMP >> 12);

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TEMP_CALIB = 3'd0,
    REG_PRESS_LO   = 3'd1,
    REG_PRESS_HI   = 3'd2,
    REG_MISC_CALIB = 3'd3,
    REG_HUM_CALIB  = 3'd4,
    REG_HAS_HUM    = 3'd5
  } reg_idx_e;

  // Decoded calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
    logic        has_hum;
  } calib_t;

  // Results that ride alongside the pressure division
  typedef struct packed {
    logic             dvz;
    logic [HUM_W-1:0] hum;
    logic [31:0]      temp;
  } side_t;

  function automatic logic [63:0] sx16to64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx16to32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8to32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return $signed(x) >>> n;
  endfunction

endpackage

// ===== design/ensc_mul64.sv =====
module ensc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] p_q;

  // Form the 32x32 partial products, then add them modulo 2^64
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[31:0] * b_i[31:0];
      lh_q <= a_i[31:0] * b_i[63:32];
      hl_q <= a_i[63:32] * b_i[31:0];
      p_q  <= ll_q + {lh_q + hl_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

// ===== design/ensc_front.sv =====
module ensc_front (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [19:0]          adc_press_i,
  input  logic [19:0]          adc_temp_i,
  input  logic [15:0]          adc_hum_i,
  input  ensc_pkg::calib_t     calib_i,
  output logic [63:0]          num_o,
  output logic [30:0]          dv_o,
  output ensc_pkg::side_t      side_o
);
  import ensc_pkg::*;

  // Temperature
  logic signed [18:0] ta;
  logic signed [17:0] td;
  logic signed [34:0] tv1p_q;
  logic signed [35:0] dsq_q;
  logic signed [23:0] dsh;
  logic signed [23:0] tv1_q;
  logic signed [39:0] tv2p_q;
  logic signed [31:0] tf_q;
  logic signed [35:0] t5;
  logic [31:0]        temp_q;
  logic [31:0]        tdly_q [10];
  logic [19:0]        adcp_q [3];
  logic [15:0]        adch_q [4];

  assign ta  = $signed({2'b00, adc_temp_i[19:3]}) - $signed({2'b00, calib_i.t1, 1'b0});
  assign td  = $signed({2'b00, adc_temp_i[19:4]}) - $signed({2'b00, calib_i.t1});
  assign dsh = 24'(dsq_q >>> 12);
  assign t5  = tf_q * 36'sd5 + 36'sd128;

  // Fine temperature over three stages, then the Celsius result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tv1p_q    <= ta * $signed(calib_i.t2);
      dsq_q     <= td * td;
      tv1_q     <= 24'(tv1p_q >>> 11);
      tv2p_q    <= dsh * $signed(calib_i.t3);
      tf_q      <= tv1_q + 32'(tv2p_q >>> 14);
      temp_q    <= 32'(t5 >>> 8);
      adcp_q[0] <= adc_press_i;
      adcp_q[1] <= adcp_q[0];
      adcp_q[2] <= adcp_q[1];
      adch_q[0] <= adc_hum_i;
      adch_q[1] <= adch_q[0];
      adch_q[2] <= adch_q[1];
      adch_q[3] <= adch_q[2];
      tdly_q[0] <= temp_q;
      for (int i = 1; i < 10; i++) begin
        tdly_q[i] <= tdly_q[i-1];
      end
    end
  end

  // Pressure numerator and divisor
  logic [63:0] pv1_q;
  logic [20:0] pdiff_q;
  logic [20:0] pdly_q [7];
  logic [63:0] sq, pb, pc, pd, pe, pf, pg;
  logic [63:0] pb7_q, pb8_q, pc7_q, pc8_q;
  logic [63:0] v2_q, v2a_q, v2b_q, x_q, pn_q;
  logic [30:0] dv_q, dva_q, dvb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pv1_q     <= {{32{tf_q[31]}}, tf_q} - 64'(P_TF_OFF);
      pdiff_q   <= 21'(P_BASE) - {1'b0, adcp_q[2]};
      pdly_q[0] <= pdiff_q;
      for (int i = 1; i < 7; i++) begin
        pdly_q[i] <= pdly_q[i-1];
      end
      pb7_q <= pb;
      pb8_q <= pb7_q;
      pc7_q <= pc;
      pc8_q <= pc7_q;
      v2_q  <= pd + (pb8_q << 17) + (sx16to64(calib_i.p4) << 35);
      x_q   <= asr64(pe, 8) + (pc8_q << 12) + (64'd1 << 47);
      v2a_q <= v2_q;
      v2b_q <= v2a_q;
      dv_q  <= pf[63:33];
      pn_q  <= ({43'b0, pdly_q[6]} << 31) - v2b_q;
      dva_q <= dv_q;
      dvb_q <= dva_q;
    end
  end

  ensc_mul64 u_mul_a (.clk_i, .en_i, .a_i(pv1_q), .b_i(pv1_q), .p_o(sq));
  ensc_mul64 u_mul_b (.clk_i, .en_i, .a_i(pv1_q), .b_i(sx16to64(calib_i.p5)), .p_o(pb));
  ensc_mul64 u_mul_c (.clk_i, .en_i, .a_i(pv1_q), .b_i(sx16to64(calib_i.p2)), .p_o(pc));
  ensc_mul64 u_mul_d (.clk_i, .en_i, .a_i(sq), .b_i(sx16to64(calib_i.p6)), .p_o(pd));
  ensc_mul64 u_mul_e (.clk_i, .en_i, .a_i(sq), .b_i(sx16to64(calib_i.p3)), .p_o(pe));
  ensc_mul64 u_mul_f (.clk_i, .en_i, .a_i(x_q), .b_i({48'b0, calib_i.p1}), .p_o(pf));
  ensc_mul64 u_mul_g (.clk_i, .en_i, .a_i(pn_q), .b_i(64'(P_SCALE)), .p_o(pg));

  // Humidity, one 32-bit product per register
  logic [31:0]      hv_q, hx0_q, hy0_q, hz0_q, hx_q, hy_q, hz_q;
  logic [31:0]      hxa_q, hxb_q, hw0_q, hw_q, hv2_q, hv2a_q, hv2b_q;
  logic [31:0]      hss_q, ht_q, hv3;
  logic [HUM_W-1:0] hum_d, hum_q, huma_q, humb_q;

  assign hv3 = hv2b_q - asr32(ht_q, 4);

  // Clamp to the valid range, drop when the sensor has no humidity channel
  always_comb begin
    if (!calib_i.has_hum || hv3[31]) begin
      hum_d = '0;
    end else if (hv3 > 32'(H_CLAMP)) begin
      hum_d = HUM_MAX;
    end else begin
      hum_d = hv3[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hv_q   <= tf_q - 32'(H_TF_OFF);
      hx0_q  <= ({16'b0, adch_q[3]} << 14) - (sx16to32(calib_i.h4) << 20)
                - (sx16to32(calib_i.h5) * hv_q);
      hy0_q  <= hv_q * sx8to32(calib_i.h6);
      hz0_q  <= hv_q * {24'b0, calib_i.h3};
      hx_q   <= asr32(hx0_q + 32'(H_ROUND1), 15);
      hy_q   <= asr32(hy0_q, 10);
      hz_q   <= asr32(hz0_q, 11) + 32'(H_BIAS2);
      hxa_q  <= hx_q;
      hw0_q  <= asr32(hy_q * hz_q, 10) + 32'(H_BIAS);
      hxb_q  <= hxa_q;
      hw_q   <= asr32(hw0_q * sx16to32(calib_i.h2) + 32'(H_ROUND2), 14);
      hv2_q  <= hxb_q * hw_q;
      hss_q  <= asr32(hv2_q, 15) * asr32(hv2_q, 15);
      hv2a_q <= hv2_q;
      ht_q   <= asr32(hss_q, 7) * {24'b0, calib_i.h1};
      hv2b_q <= hv2a_q;
      hum_q  <= hum_d;
      huma_q <= hum_q;
      humb_q <= huma_q;
    end
  end

  assign num_o       = pg;
  assign dv_o        = dvb_q;
  assign side_o.dvz  = (dvb_q == '0);
  assign side_o.hum  = humb_q;
  assign side_o.temp = tdly_q[9];

endmodule

// ===== design/ensc_div.sv =====
module ensc_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ensc_pkg::NUM_W-1:0]     num_i,
  input  logic [ensc_pkg::DIV_W-1:0]     dv_i,
  input  ensc_pkg::side_t                side_i,
  output logic [ensc_pkg::NUM_W-1:0]     q_o,
  output ensc_pkg::side_t                side_o
);
  import ensc_pkg::*;

  logic [NUM_W-1:0] an_q;
  logic [DIV_W-1:0] ad_q;
  logic             neg_q;
  side_t            side_q;

  // Take magnitudes and the quotient sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q   <= num_i[NUM_W-1] ? ('0 - num_i) : num_i;
      ad_q   <= dv_i[DIV_W-1] ? ('0 - dv_i) : dv_i;
      neg_q  <= num_i[NUM_W-1] ^ dv_i[DIV_W-1];
      side_q <= side_i;
    end
  end

  logic [DIV_W-1:0] rem_q  [NUM_W];
  logic [NUM_W-1:0] nq_q   [NUM_W];
  logic [DIV_W-1:0] ads_q  [NUM_W];
  logic             negs_q [NUM_W];
  side_t            sides_q[NUM_W];

  // One restoring step per stage, quotient bits shift in from the right
  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] ad_in;
    logic [NUM_W-1:0] n_in;
    logic             neg_in;
    side_t            side_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign ad_in   = ad_q;
      assign n_in    = an_q;
      assign neg_in  = neg_q;
      assign side_in = side_q;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign ad_in   = ads_q[i-1];
      assign n_in    = nq_q[i-1];
      assign neg_in  = negs_q[i-1];
      assign side_in = sides_q[i-1];
    end

    assign trial = {rem_in, n_in[NUM_W-1]};
    assign diff  = trial - {1'b0, ad_in};
    assign ge    = (trial >= {1'b0, ad_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]   <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        nq_q[i]    <= {n_in[NUM_W-2:0], ge};
        ads_q[i]   <= ad_in;
        negs_q[i]  <= neg_in;
        sides_q[i] <= side_in;
      end
    end
  end

  logic [NUM_W-1:0] q_q;
  side_t            sideo_q;

  // Apply the sign to the quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= negs_q[NUM_W-1] ? ('0 - nq_q[NUM_W-1]) : nq_q[NUM_W-1];
      sideo_q <= sides_q[NUM_W-1];
    end
  end

  assign q_o    = q_q;
  assign side_o = sideo_q;

endmodule

// ===== design/ensc_back.sv =====
module ensc_back (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ensc_pkg::NUM_W-1:0] q_i,
  input  ensc_pkg::side_t            side_i,
  input  ensc_pkg::calib_t           calib_i,
  output logic [31:0]                press_o,
  output ensc_pkg::side_t            side_o
);
  import ensc_pkg::*;

  logic [63:0] ph, pi, pj;
  logic [63:0] q1_q, q2_q, q3_q, q4_q;
  logic [63:0] v2a_q, v2b_q, s_q;
  logic [31:0] press_q;
  side_t       sd_q [5];
  side_t       sideo_q;

  ensc_mul64 u_mul_h (.clk_i, .en_i, .a_i(sx16to64(calib_i.p9)), .b_i(asr64(q_i, 13)),
                      .p_o(ph));
  ensc_mul64 u_mul_i (.clk_i, .en_i, .a_i(sx16to64(calib_i.p8)), .b_i(q_i), .p_o(pi));
  ensc_mul64 u_mul_j (.clk_i, .en_i, .a_i(ph), .b_i(asr64(q2_q, 13)), .p_o(pj));

  // Second-order correction, then scale to Q24.8
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q     <= q_i;
      q2_q     <= q1_q;
      q3_q     <= q2_q;
      q4_q     <= q3_q;
      v2a_q    <= asr64(pi, 19);
      v2b_q    <= v2a_q;
      s_q      <= q4_q + asr64(pj, 25) + v2b_q;
      press_q  <= sd_q[4].dvz ? '0
                  : 32'(asr64(s_q, 8) + (sx16to64(calib_i.p7) << 4));
      sd_q[0]  <= side_i;
      for (int i = 1; i < 5; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      sideo_q  <= sd_q[4];
    end
  end

  assign press_o = press_q;
  assign side_o  = sideo_q;

endmodule

// ===== design/env_sensor_compensation_top.sv =====
// Channel   Dir  Payload
// s_axis    in   tdata[55:0]: adc_press, adc_temp, adc_hum
// m_axis    out  tdata[87:0]: temp_centi, press_q24_8, hum_q7_10, zero pad
// cfg       in   cfg_index_i selects a calibration register, cfg_data_i is its value
//
// One reading enters per cycle while the output is not stalled.
// The pressure divider has 64 restoring stages, one quotient bit per stage.
// Reset clears the calibration registers and all stage valid bits.
// A stalled output freezes the whole pipeline, so s_axis_tready_o drops with it.
module env_sensor_compensation_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [55:0]                     s_axis_tdata_i,  // adc_press, adc_temp, adc_hum
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [87:0]                     m_axis_tdata_o,  // temp_centi, press_q24_8, hum_q7_10
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ensc_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);
  import ensc_pkg::*;

  logic [47:0] temp_calib_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [47:0] misc_calib_q;
  logic [39:0] hum_calib_q;
  logic        has_hum_q;
  calib_t      calib;

  assign cfg_ready_o = 1'b1;

  // Store calibration words, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_lo_q   <= '0;
      press_hi_q   <= '0;
      misc_calib_q <= '0;
      hum_calib_q  <= '0;
      has_hum_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TEMP_CALIB: temp_calib_q <= cfg_data_i[47:0];
        REG_PRESS_LO:   press_lo_q   <= cfg_data_i;
        REG_PRESS_HI:   press_hi_q   <= cfg_data_i;
        REG_MISC_CALIB: misc_calib_q <= cfg_data_i[47:0];
        REG_HUM_CALIB:  hum_calib_q  <= cfg_data_i[39:0];
        REG_HAS_HUM:    has_hum_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Split the registers into calibration words
  assign calib.t1      = temp_calib_q[15:0];
  assign calib.t2      = temp_calib_q[31:16];
  assign calib.t3      = temp_calib_q[47:32];
  assign calib.p1      = press_lo_q[15:0];
  assign calib.p2      = press_lo_q[31:16];
  assign calib.p3      = press_lo_q[47:32];
  assign calib.p4      = press_lo_q[63:48];
  assign calib.p5      = press_hi_q[15:0];
  assign calib.p6      = press_hi_q[31:16];
  assign calib.p7      = press_hi_q[47:32];
  assign calib.p8      = press_hi_q[63:48];
  assign calib.p9      = misc_calib_q[15:0];
  assign calib.h1      = misc_calib_q[23:16];
  assign calib.h2      = misc_calib_q[39:24];
  assign calib.h3      = misc_calib_q[47:40];
  assign calib.h4      = hum_calib_q[15:0];
  assign calib.h5      = hum_calib_q[31:16];
  assign calib.h6      = hum_calib_q[39:32];
  assign calib.has_hum = has_hum_q;

  // Advance the whole pipeline unless a result waits at the output
  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic [NUM_W-1:0] num;
  logic [DIV_W-1:0] dv;
  logic [NUM_W-1:0] quo;
  side_t            side_f, side_d, side_b;
  logic [31:0]      press;

  ensc_front u_front (
    .clk_i,
    .en_i        (en),
    .adc_press_i (s_axis_tdata_i[19:0]),
    .adc_temp_i  (s_axis_tdata_i[39:20]),
    .adc_hum_i   (s_axis_tdata_i[55:40]),
    .calib_i     (calib),
    .num_o       (num),
    .dv_o        (dv),
    .side_o      (side_f)
  );

  ensc_div u_div (
    .clk_i,
    .en_i   (en),
    .num_i  (num),
    .dv_i   (dv),
    .side_i (side_f),
    .q_o    (quo),
    .side_o (side_d)
  );

  ensc_back u_back (
    .clk_i,
    .en_i    (en),
    .q_i     (quo),
    .side_i  (side_d),
    .calib_i (calib),
    .press_o (press),
    .side_o  (side_b)
  );

  // Valid bits follow the data through every stage
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  m_valid_q;
  logic [87:0]           m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid_i};
      m_valid_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // Hold the result until its transfer out
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= {7'b0, side_b.hum, press, side_b.temp};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted reading did not enter the pipeline");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

  a_hum_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_data_q[80:64] <= HUM_MAX)
    else $error("humidity result above clamp");

  a_hum_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !has_hum_q |-> m_data_q[80:64] == '0)
    else $error("humidity reported while disabled");

endmodule
